[rtl/dwsg_pkg.sv]
// ============================================================================
// dwsg_pkg
// Shared types, constants and the quarter-wave sine table builder for the
// waveform sample generator.
// ============================================================================
package dwsg_pkg;

    // one waveform period, a power of two between 16 and 1024 entries
    localparam int TABLE_SIZE = 1024;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int QTR        = TABLE_SIZE / 4;
    localparam int QA_W       = $clog2(QTR + 1);
    localparam int NUM_W      = IDX_W + 2;

    localparam int IN_W       = 10;
    localparam int CODE_W     = 10;
    localparam int CODE_MAX   = 1023;
    localparam int DUTY_W     = 7;
    localparam int DUTY_MAX   = 100;
    localparam int SQ_W       = IDX_W + DUTY_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // sine magnitude in q16, 0..65536
    localparam int SIN_W      = 17;
    localparam int OFS_W      = SIN_W + 1;
    localparam int Q16_ONE    = 65536;
    localparam int Q16_HALF   = 32768;
    localparam int SPROD_W    = OFS_W + CODE_W;
    localparam int TPROD_W    = NUM_W + CODE_W;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    localparam logic [CODE_W-1:0] RST_AMPLITUDE  = CODE_W'(511);
    localparam logic [CODE_W-1:0] RST_HIGH_LEVEL = CODE_W'(1022);
    localparam logic [CODE_W-1:0] RST_LOW_LEVEL  = CODE_W'(0);
    localparam logic [DUTY_W-1:0] RST_DUTY       = DUTY_W'(20);
    localparam logic [CODE_W-1:0] RST_DC_LEVEL   = CODE_W'(512);

    typedef enum logic [1:0] {
        WV_SINE,
        WV_TRI,
        WV_SQUARE,
        WV_DC
    } t_wave;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WAVE_TYPE,
        REG_AMPLITUDE,
        REG_HIGH_LEVEL,
        REG_LOW_LEVEL,
        REG_DUTY_PCT,
        REG_DC_LEVEL
    } t_reg_idx;

    typedef struct packed {
        t_wave              wave;
        logic [CODE_W-1:0]  amplitude;
        logic [CODE_W-1:0]  high_level;
        logic [CODE_W-1:0]  low_level;
        logic [DUTY_W-1:0]  duty_pct;
        logic [CODE_W-1:0]  dc_level;
    } t_cfg;

    // front stage result handed to the scaling stages
    typedef struct packed {
        logic               valid;
        logic               neg;
        logic [NUM_W-1:0]   num;
        logic               sq_high;
    } t_front;

    typedef logic [SIN_W-1:0] t_qrom [0:QTR];

    // quarter-wave sine, entry q is sin(pi/2 * 4q/TABLE_SIZE) in q16
    // taylor series to x^13 in q30, each term truncated
    function automatic t_qrom build_quarter_sine();
        t_qrom       rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        for (int q = 0; q <= QTR; q++) begin
            x    = (PI_HALF_Q30 * 64'(4 * q)) / 64'(TABLE_SIZE);
            x2   = (x * x) >> 30;
            sum  = longint'(x);
            term = ((x * x2) >> 30) / 64'd6;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + longint'(term);
            if (sum < 0) begin
                sum = 0;
            end
            sum = (sum + 8192) >>> 14;
            if (sum > longint'(Q16_ONE)) begin
                sum = longint'(Q16_ONE);
            end
            rom[q] = SIN_W'(sum);
        end
        return rom;
    endfunction

endpackage

[rtl/dds_waveform_sample_generator_top.sv]
// ============================================================================
// dds_waveform_sample_generator_top
// Table position in, 10-bit DAC code of the selected waveform out.
// ============================================================================
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+-------------------------------
//  sample in | start, busy (take: start&!busy)| i_sample_index[9:0]
//  code out  | o_strobe (one cycle per beat)  | o_sample_code[9:0]
//  config    | i_cfg_valid, o_cfg_ready       | i_cfg_index[2:0], i_cfg_data
//
//  one beat enters per clock; its code reaches the result ports from the
//  output register of the round/select stage, marked by o_strobe
//  stages: index register, sine table read, multiply, round/select; the
//  table read and the amplitude multiplier set the stage depth
//  synchronous active-low reset clears the valid pipe and loads square wave,
//  20 percent duty; busy is tied low and o_cfg_ready high, nothing stalls
//
module dds_waveform_sample_generator_top import dwsg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample channel
    input  logic                  start,
    output logic                  busy,
    input  logic [IN_W-1:0]       i_sample_index,
    // result channel
    output logic                  o_strobe,
    output logic [CODE_W-1:0]     o_sample_code,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg              w_cfg;
    t_front            w_front;
    logic [SIN_W-1:0]  w_sin;
    logic              w_take;

    // fully pipelined, never busy
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_take      = start & ~busy;

    // register file; the user must write it only between bursts, the block does not enforce it
    dwsg_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid & o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // index capture, quadrant fold, sine lookup, duty compare
    dwsg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_take),
        .i_index (i_sample_index),
        .i_duty  (w_cfg.duty_pct),
        .o_front (w_front),
        .o_sin   (w_sin)
    );

    // amplitude scale, rounding, saturation and output register
    dwsg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_front  (w_front),
        .i_sin    (w_sin),
        .i_cfg    (w_cfg),
        .o_strobe (o_strobe),
        .o_code   (o_sample_code)
    );

endmodule

[rtl/dwsg_cfg_regs.sv]
// ============================================================================
// dwsg_cfg_regs
// Configuration register file, one write beat per cycle, duty clamped.
// ============================================================================
module dwsg_cfg_regs import dwsg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg              r_cfg;
    t_cfg              n_cfg;
    logic [DUTY_W-1:0] n_duty;

    always_comb begin
        n_duty = i_wr_data[DUTY_W-1:0];
        if (n_duty > DUTY_W'(DUTY_MAX)) begin
            n_duty = DUTY_W'(DUTY_MAX);
        end
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (t_reg_idx'(i_wr_index))
                REG_WAVE_TYPE:  n_cfg.wave       = t_wave'(i_wr_data[1:0]);
                REG_AMPLITUDE:  n_cfg.amplitude  = i_wr_data[CODE_W-1:0];
                REG_HIGH_LEVEL: n_cfg.high_level = i_wr_data[CODE_W-1:0];
                REG_LOW_LEVEL:  n_cfg.low_level  = i_wr_data[CODE_W-1:0];
                REG_DUTY_PCT:   n_cfg.duty_pct   = n_duty;
                REG_DC_LEVEL:   n_cfg.dc_level   = i_wr_data[CODE_W-1:0];
                default:        n_cfg            = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wave       <= WV_SQUARE;
            r_cfg.amplitude  <= RST_AMPLITUDE;
            r_cfg.high_level <= RST_HIGH_LEVEL;
            r_cfg.low_level  <= RST_LOW_LEVEL;
            r_cfg.duty_pct   <= RST_DUTY;
            r_cfg.dc_level   <= RST_DC_LEVEL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/dwsg_sine_rom.sv]
// ============================================================================
// dwsg_sine_rom
// Quarter-wave sine table in q16 with registered read data.
// ============================================================================
module dwsg_sine_rom import dwsg_pkg::*; (
    input  logic             i_clk,
    input  logic [QA_W-1:0]  i_addr,
    output logic [SIN_W-1:0] o_data
);

    localparam t_qrom SINE_ROM = build_quarter_sine();

    logic [SIN_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= SINE_ROM[i_addr];
    end

    assign o_data = r_data;

endmodule

[rtl/dwsg_front.sv]
// ============================================================================
// dwsg_front
// Index capture, quadrant fold into the sine table, triangle numerator and
// square duty compare.
// ============================================================================
module dwsg_front import dwsg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [IN_W-1:0]   i_index,
    input  logic [DUTY_W-1:0] i_duty,
    output t_front            o_front,
    output logic [SIN_W-1:0]  o_sin
);

    logic              r_v1;
    logic [IDX_W-1:0]  r_idx1;
    logic              r_v2;
    logic              r_neg2;
    logic [NUM_W-1:0]  r_num2;
    logic              r_sq2;

    logic [1:0]        n_quad;
    logic [IDX_W-3:0]  n_low;
    logic [QA_W-1:0]   n_addr;
    logic [NUM_W-1:0]  n_four_i;
    logic [NUM_W-1:0]  n_num;
    logic [IDX_W:0]    n_idx_p1;
    logic [SQ_W-1:0]   n_lhs;
    logic [SQ_W-1:0]   n_rhs;

    // stage 1: capture the index, wrapped to the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= i_index[IDX_W-1:0];
    end

    // stage 2: fold, table address, triangle and square terms
    always_comb begin
        n_quad   = r_idx1[IDX_W-1 -: 2];
        n_low    = r_idx1[IDX_W-3:0];
        n_addr   = n_quad[0] ? (QA_W'(QTR) - QA_W'(n_low)) : QA_W'(n_low);
        n_four_i = {r_idx1, 2'b00};
        unique case (n_quad)
            2'd0:    n_num = n_four_i + NUM_W'(TABLE_SIZE);
            2'd3:    n_num = n_four_i - NUM_W'(3 * TABLE_SIZE);
            default: n_num = NUM_W'(3 * TABLE_SIZE) - n_four_i;
        endcase
        // i < floor(duty*N/100) is the same as 100*(i+1) <= duty*N
        n_idx_p1 = {1'b0, r_idx1} + (IDX_W + 1)'(1);
        n_lhs    = SQ_W'(n_idx_p1) * SQ_W'(DUTY_MAX);
        n_rhs    = SQ_W'(i_duty) << IDX_W;
    end

    dwsg_sine_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (n_addr),
        .o_data (o_sin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg2 <= n_quad[1];
        r_num2 <= n_num;
        r_sq2  <= (n_lhs <= n_rhs);
    end

    assign o_front = '{valid: r_v2, neg: r_neg2, num: r_num2, sq_high: r_sq2};

endmodule

[rtl/dwsg_back.sv]
// ============================================================================
// dwsg_back
// Amplitude scaling, rounding, saturation and waveform select into the
// output register.
// ============================================================================
module dwsg_back import dwsg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_front            i_front,
    input  logic [SIN_W-1:0]  i_sin,
    input  t_cfg              i_cfg,
    output logic              o_strobe,
    output logic [CODE_W-1:0] o_code
);

    localparam int SQ_OUT_W = SPROD_W + 1 - 16;
    localparam int TQ_OUT_W = TPROD_W + 1 - IDX_W;

    logic [OFS_W-1:0]     n_ofs;
    logic                 r_v3;
    logic [SPROD_W-1:0]   r_sprod;
    logic [TPROD_W-1:0]   r_tprod;
    logic                 r_sq3;

    logic [SPROD_W:0]     n_sround;
    logic [TPROD_W:0]     n_tround;
    logic [SQ_OUT_W-1:0]  n_sq;
    logic [TQ_OUT_W-1:0]  n_tq;
    logic [CODE_W-1:0]    n_scode;
    logic [CODE_W-1:0]    n_tcode;
    logic [CODE_W-1:0]    n_code;

    logic                 r_strobe;
    logic [CODE_W-1:0]    r_code;

    // stage 3: offset sine into 0..2 and scale, triangle scale
    assign n_ofs = i_front.neg ? (OFS_W'(Q16_ONE) - OFS_W'(i_sin))
                               : (OFS_W'(Q16_ONE) + OFS_W'(i_sin));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= i_front.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sprod <= SPROD_W'(n_ofs) * SPROD_W'(i_cfg.amplitude);
        r_tprod <= TPROD_W'(i_front.num) * TPROD_W'(i_cfg.amplitude);
        r_sq3   <= i_front.sq_high;
    end

    // stage 4: round half up, saturate, select
    always_comb begin
        n_sround = {1'b0, r_sprod} + (SPROD_W + 1)'(Q16_HALF);
        n_tround = {1'b0, r_tprod} + (TPROD_W + 1)'(TABLE_SIZE / 2);
        n_sq     = n_sround[SPROD_W:16];
        n_tq     = n_tround[TPROD_W:IDX_W];
        n_scode  = (n_sq > SQ_OUT_W'(CODE_MAX)) ? CODE_W'(CODE_MAX) : n_sq[CODE_W-1:0];
        n_tcode  = (n_tq > TQ_OUT_W'(CODE_MAX)) ? CODE_W'(CODE_MAX) : n_tq[CODE_W-1:0];
        unique case (i_cfg.wave)
            WV_SINE:   n_code = n_scode;
            WV_TRI:    n_code = n_tcode;
            WV_SQUARE: n_code = r_sq3 ? i_cfg.high_level : i_cfg.low_level;
            WV_DC:     n_code = i_cfg.dc_level;
            default:   n_code = i_cfg.dc_level;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

    assign o_strobe = r_strobe;
    assign o_code   = r_code;

endmodule
